/* design/csvfp_pkg.sv */
// Shared types and constants of the CSV field parser.
// Used by the output register, the top level, the checker and the testbench; depends on nothing.

package csvfp_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_UNCLOSED    = 2'd1,
        ERR_AFTER_QUOTE = 2'd2,
        ERR_OVERFLOW    = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       field_end;
        logic       record_end;
        t_err       error_code;
        logic       last;
    } t_result;

    function automatic t_result make_result(input logic [7:0] c, input logic cv,
                                            input logic fe, input logic re,
                                            input t_err err, input logic lst);
        t_result r;
        r.out_char   = cv ? c : 8'h00;
        r.char_valid = cv;
        r.field_end  = fe;
        r.record_end = re;
        r.error_code = err;
        r.last       = lst;
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

endpackage

/* design/csv_field_parser.sv */
// Top level of the CSV field parser: parse-mode FSM, flush sequencer.
// Depends on csvfp_pkg, csvfp_ws_buf and csvfp_out_reg.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_ch
//   result    out        o_out_valid / i_out_ready  o_out_char, o_char_valid, o_field_end,
//                                                   o_record_end, o_error_code, o_last
//
// Most items give at most one result item.
// A non-space byte that releases k held whitespace bytes starts a flush after the accepting
// cycle: each held byte is read through the single buffer read port and then emitted, and
// last the byte itself is emitted.
// Reset clears the parse mode, the held count, the sequencer and the output valid;
// the buffer contents are not cleared, since only entries below the count are read.
// A stalled result side holds the output register and blocks further input items.

module csv_field_parser #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_field_end,
    output logic       o_record_end,
    output logic [1:0] o_error_code,
    output logic       o_last
);

    localparam int AW = $clog2(PENDING_DEPTH > 1 ? PENDING_DEPTH : 2);
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [5:0] {
        M_SKIP    = 6'b000001,
        M_PLAIN   = 6'b000010,
        M_QUOTED  = 6'b000100,
        M_QCLOSE  = 6'b001000,
        M_AFTERQ  = 6'b010000,
        M_DISCARD = 6'b100000
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_FL_RD   = 4'b0010,
        S_FL_EMIT = 4'b0100,
        S_EMIT_CH = 4'b1000
    } t_seq;

    t_mode   r_mode, n_mode;
    t_seq    r_seq, n_seq;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [7:0]    r_hold, n_hold;

    logic               can_load;
    logic               load;
    csvfp_pkg::t_result res;
    logic               accept;
    logic               wr_en;
    logic               rd_en;
    logic               start_flush;
    logic [7:0]         rdata;
    logic               out_valid;
    csvfp_pkg::t_result out_res;

    assign o_in_ready = (r_seq == S_IDLE) && can_load;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_mode      = r_mode;
        n_seq       = r_seq;
        n_count     = r_count;
        n_idx       = r_idx;
        n_hold      = r_hold;
        load        = 1'b0;
        res         = csvfp_pkg::make_result(8'h00, 1'b0, 1'b0, 1'b0,
                                             csvfp_pkg::ERR_NONE, 1'b1);
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        start_flush = 1'b0;

        case (r_seq)
            S_IDLE: begin
                if (accept) begin
                    case (r_mode)
                        M_PLAIN: begin
                            if (i_ch == csvfp_pkg::CHAR_NUL || i_ch == csvfp_pkg::CHAR_COMMA) begin
                                n_count = '0;
                                n_mode  = M_SKIP;
                                load    = 1'b1;
                                res     = csvfp_pkg::make_result(8'h00, 1'b0, 1'b1,
                                              i_ch == csvfp_pkg::CHAR_NUL,
                                              csvfp_pkg::ERR_NONE, 1'b1);
                            end else if (csvfp_pkg::is_ws(i_ch)) begin
                                if (r_count >= CW'(PENDING_DEPTH)) begin
                                    n_count = '0;
                                    n_mode  = M_DISCARD;
                                    load    = 1'b1;
                                    res     = csvfp_pkg::make_result(8'h00, 1'b0, 1'b0,
                                                  1'b0, csvfp_pkg::ERR_OVERFLOW, 1'b1);
                                end else begin
                                    wr_en   = 1'b1;
                                    n_count = r_count + CW'(1);
                                end
                            end else if (r_count == '0) begin
                                load = 1'b1;
                                res  = csvfp_pkg::make_result(i_ch, 1'b1, 1'b0, 1'b0,
                                                              csvfp_pkg::ERR_NONE, 1'b1);
                            end else begin
                                start_flush = 1'b1;
                                n_hold      = i_ch;
                                n_idx       = '0;
                                n_seq       = S_FL_RD;
                            end
                        end
                        M_QUOTED: begin
                            if (i_ch == csvfp_pkg::CHAR_NUL) begin
                                n_mode = M_SKIP;
                                load   = 1'b1;
                                res    = csvfp_pkg::make_result(8'h00, 1'b0, 1'b0, 1'b1,
                                                                csvfp_pkg::ERR_UNCLOSED, 1'b1);
                            end else if (i_ch == csvfp_pkg::CHAR_QUOTE) begin
                                n_mode = M_QCLOSE;
                            end else begin
                                load = 1'b1;
                                res  = csvfp_pkg::make_result(i_ch, 1'b1, 1'b0, 1'b0,
                                                              csvfp_pkg::ERR_NONE, 1'b1);
                            end
                        end
                        M_QCLOSE, M_AFTERQ: begin
                            if (r_mode == M_QCLOSE && i_ch == csvfp_pkg::CHAR_QUOTE) begin
                                // A doubled quote stands for one quote.
                                n_mode = M_QUOTED;
                                load   = 1'b1;
                                res    = csvfp_pkg::make_result(csvfp_pkg::CHAR_QUOTE, 1'b1,
                                             1'b0, 1'b0, csvfp_pkg::ERR_NONE, 1'b1);
                            end else if (i_ch == csvfp_pkg::CHAR_NUL) begin
                                n_mode = M_SKIP;
                                load   = 1'b1;
                                res    = csvfp_pkg::make_result(8'h00, 1'b0, 1'b1, 1'b1,
                                                                csvfp_pkg::ERR_NONE, 1'b1);
                            end else if (i_ch == csvfp_pkg::CHAR_COMMA) begin
                                n_mode = M_SKIP;
                                load   = 1'b1;
                                res    = csvfp_pkg::make_result(8'h00, 1'b0, 1'b1, 1'b0,
                                                                csvfp_pkg::ERR_NONE, 1'b1);
                            end else if (csvfp_pkg::is_ws(i_ch)) begin
                                n_mode = M_AFTERQ;
                            end else begin
                                n_mode = M_DISCARD;
                                load   = 1'b1;
                                res    = csvfp_pkg::make_result(8'h00, 1'b0, 1'b0, 1'b0,
                                             csvfp_pkg::ERR_AFTER_QUOTE, 1'b1);
                            end
                        end
                        M_DISCARD: begin
                            if (i_ch == csvfp_pkg::CHAR_NUL) begin
                                n_mode = M_SKIP;
                                load   = 1'b1;
                                res    = csvfp_pkg::make_result(8'h00, 1'b0, 1'b0, 1'b1,
                                                                csvfp_pkg::ERR_NONE, 1'b1);
                            end
                        end
                        default: begin
                            n_mode  = M_SKIP;
                            n_count = '0;
                            if (i_ch == csvfp_pkg::CHAR_NUL) begin
                                load = 1'b1;
                                res  = csvfp_pkg::make_result(8'h00, 1'b0, 1'b0, 1'b1,
                                                              csvfp_pkg::ERR_NONE, 1'b1);
                            end else if (csvfp_pkg::is_ws(i_ch)) begin
                                n_mode = M_SKIP;
                            end else if (i_ch == csvfp_pkg::CHAR_QUOTE) begin
                                n_mode = M_QUOTED;
                            end else if (i_ch == csvfp_pkg::CHAR_COMMA) begin
                                load = 1'b1;
                                res  = csvfp_pkg::make_result(8'h00, 1'b0, 1'b1, 1'b0,
                                                              csvfp_pkg::ERR_NONE, 1'b1);
                            end else begin
                                n_mode = M_PLAIN;
                                load   = 1'b1;
                                res    = csvfp_pkg::make_result(i_ch, 1'b1, 1'b0, 1'b0,
                                                                csvfp_pkg::ERR_NONE, 1'b1);
                            end
                        end
                    endcase
                end
            end
            S_FL_RD: begin
                rd_en = 1'b1;
                n_seq = S_FL_EMIT;
            end
            S_FL_EMIT: begin
                if (can_load) begin
                    load = 1'b1;
                    res  = csvfp_pkg::make_result(rdata, 1'b1, 1'b0, 1'b0,
                                                  csvfp_pkg::ERR_NONE, 1'b0);
                    if (r_idx + CW'(1) == r_count) begin
                        n_seq = S_EMIT_CH;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_seq = S_FL_RD;
                    end
                end
            end
            S_EMIT_CH: begin
                if (can_load) begin
                    load    = 1'b1;
                    res     = csvfp_pkg::make_result(r_hold, 1'b1, 1'b0, 1'b0,
                                                     csvfp_pkg::ERR_NONE, 1'b1);
                    n_count = '0;
                    n_seq   = S_IDLE;
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_SKIP;
            r_seq   <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_seq   <= n_seq;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    csvfp_ws_buf #(
        .DEPTH (PENDING_DEPTH),
        .AW    (AW)
    ) u_ws_buf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_ch),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    csvfp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_valid     (out_valid),
        .o_res       (out_res)
    );

    assign o_out_valid  = out_valid;
    assign o_out_char   = out_res.out_char;
    assign o_char_valid = out_res.char_valid;
    assign o_field_end  = out_res.field_end;
    assign o_record_end = out_res.record_end;
    assign o_error_code = out_res.error_code;
    assign o_last       = out_res.last;

    // A flush only starts with held bytes, and its read index stays below the count.
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_FL_RD || r_seq == S_FL_EMIT) |-> (r_count != '0 && r_idx < r_count))
        else $error("flush index out of range of held bytes");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_count < CW'(PENDING_DEPTH) && r_mode == M_PLAIN))
        else $error("whitespace buffer written beyond its depth");

    // Held bytes exist only inside an unquoted field.
    a_count_plain_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_mode == M_PLAIN))
        else $error("held whitespace outside an unquoted field");

    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_flush |=> (!o_in_ready && r_seq == S_FL_RD))
        else $error("input accepted while a flush is pending");

    // Every flush ends with the held byte, which closes the item.
    a_flush_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_EMIT_CH && load) |-> res.last)
        else $error("held byte emitted without last");

endmodule

/* design/csvfp_ws_buf.sv */
// Held-whitespace buffer: one write port, one registered read port.
// Stand-alone; no package needed.

module csvfp_ws_buf #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read, so a stalled consumer sees it stable.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/csvfp_out_reg.sv */
// One-entry output register for result items.
// Depends on csvfp_pkg for the result struct.

module csvfp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  csvfp_pkg::t_result i_res,
    input  logic               i_out_ready,
    output logic               o_can_load,
    output logic               o_valid,
    output csvfp_pkg::t_result o_res
);

    logic               r_valid;
    logic               n_valid;
    csvfp_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* tb/sv/csv_field_parser_checker.sv */
// Scoreboard for the CSV field parser: predicts the result items of every accepted
// input item and compares the result channel against them in order.
// Depends on csvfp_pkg for the result struct, the error codes and the character constants.

module csv_field_parser_checker
    import csvfp_pkg::*;
#(
    parameter int HOLD_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_char_valid,
    input  logic       i_field_end,
    input  logic       i_record_end,
    input  logic [1:0] i_error_code,
    input  logic       i_last,
    output int         o_mismatches,
    output int         o_checked,
    output int         o_outstanding
);

    typedef enum logic [2:0] {
        SCAN_SKIP,
        SCAN_PLAIN,
        SCAN_QUOTED,
        SCAN_QCLOSE,
        SCAN_AFTERQ,
        SCAN_DISCARD
    } t_scan;

    t_scan      scan_mode = SCAN_SKIP;
    logic [7:0] held_ws [HOLD_DEPTH];
    int         held_count = 0;
    t_result    expected_q [$];
    t_result    step_results [$];

    function automatic logic blank_byte(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic t_result result_of(input logic [7:0] c, input logic cv, input logic fe,
                                          input logic re, input t_err err);
        t_result r;
        r.out_char   = cv ? c : 8'h00;
        r.char_valid = cv;
        r.field_end  = fe;
        r.record_end = re;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("csv checker: %s mismatch at result %0d: got 0x%0h, expected 0x%0h",
                 what, o_checked, got, want);
        o_mismatches++;
    endtask

    // Once a quote has closed, only whitespace may come before the comma or record end.
    task automatic close_quote(input logic [7:0] c);
        if (c == CHAR_NUL) begin
            scan_mode = SCAN_SKIP;
            step_results.push_back(result_of(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE));
        end else if (c == CHAR_COMMA) begin
            scan_mode = SCAN_SKIP;
            step_results.push_back(result_of(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE));
        end else if (blank_byte(c)) begin
            scan_mode = SCAN_AFTERQ;
        end else begin
            scan_mode = SCAN_DISCARD;
            step_results.push_back(result_of(8'h00, 1'b0, 1'b0, 1'b0, ERR_AFTER_QUOTE));
        end
    endtask

    task automatic predict_byte(input logic [7:0] c);
        int      i;
        t_result tail;
        step_results.delete();
        case (scan_mode)
            SCAN_PLAIN: begin
                if (c == CHAR_NUL || c == CHAR_COMMA) begin
                    held_count = 0;
                    scan_mode  = SCAN_SKIP;
                    step_results.push_back(result_of(8'h00, 1'b0, 1'b1, c == CHAR_NUL,
                                                     ERR_NONE));
                end else if (blank_byte(c)) begin
                    if (held_count >= HOLD_DEPTH) begin
                        held_count = 0;
                        scan_mode  = SCAN_DISCARD;
                        step_results.push_back(result_of(8'h00, 1'b0, 1'b0, 1'b0,
                                                         ERR_OVERFLOW));
                    end else begin
                        held_ws[held_count] = c;
                        held_count++;
                    end
                end else begin
                    // Held whitespace is released ahead of the byte that ends the run.
                    for (i = 0; i < held_count; i++)
                        step_results.push_back(result_of(held_ws[i], 1'b1, 1'b0, 1'b0,
                                                         ERR_NONE));
                    held_count = 0;
                    step_results.push_back(result_of(c, 1'b1, 1'b0, 1'b0, ERR_NONE));
                end
            end
            SCAN_QUOTED: begin
                if (c == CHAR_NUL) begin
                    scan_mode = SCAN_SKIP;
                    step_results.push_back(result_of(8'h00, 1'b0, 1'b0, 1'b1, ERR_UNCLOSED));
                end else if (c == CHAR_QUOTE) begin
                    scan_mode = SCAN_QCLOSE;
                end else begin
                    step_results.push_back(result_of(c, 1'b1, 1'b0, 1'b0, ERR_NONE));
                end
            end
            SCAN_QCLOSE: begin
                if (c == CHAR_QUOTE) begin
                    scan_mode = SCAN_QUOTED;
                    step_results.push_back(result_of(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, ERR_NONE));
                end else begin
                    close_quote(c);
                end
            end
            SCAN_AFTERQ: begin
                close_quote(c);
            end
            SCAN_DISCARD: begin
                if (c == CHAR_NUL) begin
                    scan_mode = SCAN_SKIP;
                    step_results.push_back(result_of(8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE));
                end
            end
            default: begin
                scan_mode  = SCAN_SKIP;
                held_count = 0;
                if (c == CHAR_NUL) begin
                    step_results.push_back(result_of(8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE));
                end else if (blank_byte(c)) begin
                    scan_mode = SCAN_SKIP;
                end else if (c == CHAR_QUOTE) begin
                    scan_mode = SCAN_QUOTED;
                end else if (c == CHAR_COMMA) begin
                    step_results.push_back(result_of(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE));
                end else begin
                    scan_mode = SCAN_PLAIN;
                    step_results.push_back(result_of(c, 1'b1, 1'b0, 1'b0, ERR_NONE));
                end
            end
        endcase
        if (step_results.size() > 0) begin
            tail      = step_results.pop_back();
            tail.last = 1'b1;
            step_results.push_back(tail);
        end
        for (i = 0; i < step_results.size(); i++)
            expected_q.push_back(step_results[i]);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (!i_rst_n) begin
            scan_mode  = SCAN_SKIP;
            held_count = 0;
            expected_q.delete();
        end else begin
            // Results at this edge always belong to items accepted at earlier edges.
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", i_out_char, 8'h00);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_char !== want.out_char)
                        report_mismatch("out_char", i_out_char, want.out_char);
                    if (i_char_valid !== want.char_valid)
                        report_mismatch("char_valid", 8'(i_char_valid), 8'(want.char_valid));
                    if (i_field_end !== want.field_end)
                        report_mismatch("field_end", 8'(i_field_end), 8'(want.field_end));
                    if (i_record_end !== want.record_end)
                        report_mismatch("record_end", 8'(i_record_end), 8'(want.record_end));
                    if (i_error_code !== want.error_code)
                        report_mismatch("error_code", 8'(i_error_code), 8'(want.error_code));
                    if (i_last !== want.last)
                        report_mismatch("last", 8'(i_last), 8'(want.last));
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready)
                predict_byte(i_ch);
        end
        o_outstanding = expected_q.size();
    end

endmodule

/* tb/sv/tb_csv_field_parser.sv */
// Testbench top for the CSV field parser: clock, reset, byte stimulus, result-side
// back-pressure, watchdog and verdict. Depends on csvfp_pkg, csv_field_parser and
// csv_field_parser_checker.

module tb_csv_field_parser;

    import csvfp_pkg::*;

    localparam int HOLD_DEPTH     = 16;
    localparam int ITEM_TARGET    = 280;
    localparam int CALM_TAIL      = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 40;

    // Empty record, plain field with a quote and held whitespace, quoted field with a
    // doubled quote, unclosed quote, and text after a closing quote.
    localparam logic [7:0] DIRECTED_BYTES [25] = '{
        CHAR_NUL,
        CHAR_COMMA, 8'h61, CHAR_QUOTE, 8'h09, 8'hFF, 8'h20, CHAR_NUL,
        8'h20, CHAR_QUOTE, 8'h78, CHAR_QUOTE, CHAR_QUOTE, CHAR_QUOTE, 8'h0D, CHAR_COMMA,
        CHAR_NUL,
        CHAR_QUOTE, 8'h80, CHAR_NUL,
        CHAR_QUOTE, CHAR_QUOTE, 8'h7A, CHAR_COMMA, CHAR_NUL
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_ch        = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic       o_field_end;
    logic       o_record_end;
    logic [1:0] o_error_code;
    logic       o_last;

    int mismatches;
    int checked;
    int outstanding;
    int items_sent   = 0;
    int records_sent = 0;
    int stall_left   = 0;
    bit idle_on      = 1'b0;

    always #10 i_clk = ~i_clk;

    csv_field_parser #(
        .PENDING_DEPTH(HOLD_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_char_valid(o_char_valid),
        .o_field_end (o_field_end),
        .o_record_end(o_record_end),
        .o_error_code(o_error_code),
        .o_last      (o_last)
    );

    csv_field_parser_checker #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_ch         (i_ch),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_char   (o_out_char),
        .i_char_valid (o_char_valid),
        .i_field_end  (o_field_end),
        .i_record_end (o_record_end),
        .i_error_code (o_error_code),
        .i_last       (o_last),
        .o_mismatches (mismatches),
        .o_checked    (checked),
        .o_outstanding(outstanding)
    );

    // Result-side back-pressure: random stalls while idling is enabled.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] ws_byte();
        return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : 8'h20;
    endfunction

    // A byte that neither separates, ends nor pads a field.
    function automatic logic [7:0] text_byte(input logic allow_quote);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_COMMA || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) ||
               (!allow_quote && c == CHAR_QUOTE));
        return c;
    endfunction

    // Returns at the edge where the item is taken; valid stays high for the next item.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= b;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    task automatic send_random_record();
        logic [7:0] rec [$];
        logic [7:0] c;
        int         nfields;
        int         kind;
        int         k;
        int         j;
        nfields = $urandom_range(1, 4);
        for (k = 0; k < nfields; k++) begin
            if (k > 0)
                rec.push_back(CHAR_COMMA);
            repeat ($urandom_range(0, 2)) rec.push_back(ws_byte());
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                repeat ($urandom_range(1, 8)) rec.push_back(8'($urandom_range(1, 255)));
            end else if (kind <= 2) begin
                // Empty field: only the separator follows.
            end else if (kind <= 8) begin
                rec.push_back(text_byte(1'b0));
                for (j = $urandom_range(0, 6); j > 0; j--) begin
                    if ($urandom_range(0, 3) == 0) begin
                        // Runs of 14 to 18 straddle the buffer depth.
                        if ($urandom_range(0, 5) == 0)
                            repeat ($urandom_range(14, 18)) rec.push_back(ws_byte());
                        else
                            repeat ($urandom_range(1, 3)) rec.push_back(ws_byte());
                    end
                    rec.push_back(text_byte(1'b1));
                end
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) rec.push_back(ws_byte());
            end else begin
                rec.push_back(CHAR_QUOTE);
                for (j = $urandom_range(0, 6); j > 0; j--) begin
                    if ($urandom_range(0, 4) == 0) begin
                        rec.push_back(CHAR_QUOTE);
                        rec.push_back(CHAR_QUOTE);
                    end else begin
                        do c = 8'($urandom_range(1, 255)); while (c == CHAR_QUOTE);
                        rec.push_back(c);
                    end
                end
                // The last kind leaves the quote open for the rest of the record.
                if (kind != 15) begin
                    rec.push_back(CHAR_QUOTE);
                    if ($urandom_range(0, 2) == 0)
                        repeat ($urandom_range(1, 3)) rec.push_back(ws_byte());
                    if ($urandom_range(0, 7) == 0) begin
                        rec.push_back(text_byte(1'b1));
                        repeat ($urandom_range(0, 3)) rec.push_back(8'($urandom_range(1, 255)));
                    end
                end
            end
        end
        rec.push_back(CHAR_NUL);
        for (j = 0; j < rec.size(); j++)
            send_byte(rec[j]);
        records_sent++;
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_csv_field_parser failed");
        $finish;
    end

    initial begin : stimulus
        int  n;
        bit  paused;
        paused = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        for (n = 0; n < 25; n++) begin
            send_byte(DIRECTED_BYTES[n]);
            if (DIRECTED_BYTES[n] == CHAR_NUL)
                records_sent++;
        end
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            // Idling comes and goes per record and stops for the closing stretch.
            idle_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            send_random_record();
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        idle_on = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d records; %0d result items checked.",
                 items_sent, records_sent, checked);
        $display("Records mixed plain, quoted, empty and malformed fields with long blank runs.");
        if (mismatches == 0 && outstanding == 0)
            $display("tb_csv_field_parser passed");
        else
            $display("tb_csv_field_parser failed");
        $finish;
    end

endmodule
